### sv/brace_balanced_object_framer_top_assert.svh
// assertion macros for the brace framer, empty in synthesis
`ifndef BRACE_BALANCED_OBJECT_FRAMER_TOP_ASSERT_SVH
`define BRACE_BALANCED_OBJECT_FRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BBOF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbof check failed");

`define BBOF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbof check failed");

`else

`define BBOF_ASSERT_SAME(lbl, ante, cons)
`define BBOF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/bbof_pkg.sv
package bbof_pkg;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 13;
    localparam int LEN_W    = 12;
    localparam int DEPTH_W  = 12;
    localparam int OVF_W    = 16;

    // upper bound on the buffer size register after clamping
    localparam int BUFFER_LIMIT = 4096;
    localparam int SIZE_HI_RAW  = (BUFFER_LIMIT < 4096) ? BUFFER_LIMIT : 4096;
    localparam int SIZE_HI      = (SIZE_HI_RAW < 2) ? 2 : SIZE_HI_RAW;
    localparam int SIZE_LO      = 2;
    localparam int SIZE_RESET   = 512;

    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              is_first;
        logic              is_last;
        logic              aborted;
        logic [LEN_W-1:0]  frame_length;
        logic [OVF_W-1:0]  overflow_total;
    } frame_t;

    // clamp the written size and turn it into the largest allowed stored count
    function automatic logic [LEN_W-1:0] size_to_cap(input logic [CFG_W-1:0] size);
        logic [CFG_W-1:0] eff;
        eff = size;
        if (size < CFG_W'(SIZE_LO))
        begin
            eff = CFG_W'(SIZE_LO);
        end
        else if (size > CFG_W'(SIZE_HI))
        begin
            eff = CFG_W'(SIZE_HI);
        end
        return LEN_W'(eff - CFG_W'(1));
    endfunction

endpackage

### sv/bbof_if.sv
// received byte channel
interface bbof_rx_if import bbof_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// framed byte channel
interface bbof_frame_if import bbof_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              is_first;
    logic              is_last;
    logic              aborted;
    logic [LEN_W-1:0]  frame_length;
    logic [OVF_W-1:0]  overflow_total;

    modport source (output valid, output frame_byte, output is_first, output is_last,
                    output aborted, output frame_length, output overflow_total,
                    input ready);
    modport sink   (input valid, input frame_byte, input is_first, input is_last,
                    input aborted, input frame_length, input overflow_total,
                    output ready);
endinterface

// buffer size register write channel
interface bbof_cfg_if import bbof_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frame_buffer_bytes;

    modport source (output valid, output frame_buffer_bytes, input ready);
    modport sink   (input valid, input frame_buffer_bytes, output ready);
endinterface

### sv/brace_balanced_object_framer_top.sv
// Brace-balanced object framer: takes one received byte per transfer on rx and
// cuts JSON-style objects out of the stream, giving one transfer on frame for
// every byte stored in an object, with is_first on the opening brace and
// is_last on the brace that brings depth back to zero outside a string.
// Carriage returns and all bytes between objects give no transfer. Braces
// inside quoted strings (with backslash escapes) are not counted. A frame may
// hold at most frame_buffer_bytes - 1 bytes (the register clamps to 2..4096,
// reset 512); the byte that would exceed this gives an aborted transfer
// with zeroed fields, the framer drops the object and overflow_total counts up
// (wrapping at 16 bits). Throughput is one byte per clock while frame is not
// stalled: a byte sits in the input register, the framing logic updates the
// state as it moves into the output register, and the result is then valid on
// frame and can transfer. While a result waits on frame, rx takes one more byte
// into the input register; a byte that gives no transfer passes on, a byte that
// gives one holds rx off until the waiting result transfers.
// Register writes on cfg are taken at any cycle and should only come when
// no byte is in flight.
`include "brace_balanced_object_framer_top_assert.svh"

module brace_balanced_object_framer_top import bbof_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bbof_rx_if.sink       rx,
    bbof_frame_if.source  frame,
    bbof_cfg_if.sink      cfg
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // framing state
    logic               obj_reg;
    logic               str_reg;
    logic               esc_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [LEN_W-1:0]   cnt_reg;
    logic [OVF_W-1:0]   ovf_reg;

    // clamped size minus one, kept precomputed from the register write
    logic [LEN_W-1:0]   cap_reg;

    // output register
    logic   out_valid_reg;
    frame_t out_reg;

    // values after the byte in the input register
    logic               obj_next;
    logic               str_next;
    logic               esc_next;
    logic [DEPTH_W-1:0] depth_next;
    logic [LEN_W-1:0]   cnt_next;
    logic [OVF_W-1:0]   ovf_next;
    frame_t             res_next;
    logic               emit;
    logic               abort;
    logic               advance;

    // the output slot is free when empty or being drained this cycle
    logic out_free;
    assign out_free = !out_valid_reg || frame.ready;

    // the held byte moves on unless it has a result and the slot is busy
    assign advance  = in_valid_reg && (!emit || out_free);
    assign rx.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // per-byte framing logic
    always_comb
    begin
        logic               str_w;
        logic               esc_w;
        logic [DEPTH_W-1:0] depth_w;

        obj_next   = obj_reg;
        str_next   = str_reg;
        esc_next   = esc_reg;
        depth_next = depth_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        res_next   = '0;
        emit       = 1'b0;
        abort      = 1'b0;
        str_w      = str_reg;
        esc_w      = esc_reg;
        depth_w    = depth_reg;

        if (in_byte_reg == CH_CR)
        begin
            // carriage return: no transfer, no state change
        end
        else if (!obj_reg)
        begin
            // waiting for an opening brace; size is at least two so it always fits
            if (in_byte_reg == CH_OPEN)
            begin
                emit                    = 1'b1;
                obj_next                = 1'b1;
                str_next                = 1'b0;
                esc_next                = 1'b0;
                depth_next              = DEPTH_W'(1);
                cnt_next                = LEN_W'(1);
                res_next.frame_byte     = in_byte_reg;
                res_next.is_first       = 1'b1;
                res_next.frame_length   = LEN_W'(1);
                res_next.overflow_total = ovf_reg;
            end
        end
        else
        begin
            // string and escape tracking, depth only counts outside strings
            if (str_reg)
            begin
                priority if (esc_reg)
                begin
                    esc_w = 1'b0;
                end
                else if (in_byte_reg == CH_BSLASH)
                begin
                    esc_w = 1'b1;
                end
                else if (in_byte_reg == CH_QUOTE)
                begin
                    str_w = 1'b0;
                end
                else
                begin
                    // other bytes leave the string state alone
                end
            end
            else
            begin
                priority if (in_byte_reg == CH_QUOTE)
                begin
                    str_w = 1'b1;
                end
                else if (in_byte_reg == CH_OPEN)
                begin
                    depth_w = depth_reg + DEPTH_W'(1);
                end
                else if (in_byte_reg == CH_CLOSE)
                begin
                    depth_w = depth_reg - DEPTH_W'(1);
                end
                else
                begin
                    // other bytes leave depth alone
                end
            end

            emit = 1'b1;
            if (cnt_reg >= cap_reg)
            begin
                // buffer full: drop the object
                abort                   = 1'b1;
                ovf_next                = ovf_reg + OVF_W'(1);
                obj_next                = 1'b0;
                str_next                = 1'b0;
                esc_next                = 1'b0;
                depth_next              = '0;
                cnt_next                = '0;
                res_next.aborted        = 1'b1;
                res_next.overflow_total = ovf_reg + OVF_W'(1);
            end
            else
            begin
                res_next.frame_byte     = in_byte_reg;
                res_next.frame_length   = cnt_reg + LEN_W'(1);
                res_next.overflow_total = ovf_reg;
                if (!str_w && depth_w == '0)
                begin
                    // closing brace of the object
                    res_next.is_last = 1'b1;
                    obj_next         = 1'b0;
                    str_next         = 1'b0;
                    esc_next         = 1'b0;
                    depth_next       = '0;
                    cnt_next         = '0;
                end
                else
                begin
                    str_next   = str_w;
                    esc_next   = esc_w;
                    depth_next = depth_w;
                    cnt_next   = cnt_reg + LEN_W'(1);
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // framing state and register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_reg   <= 1'b0;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            depth_reg <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= '0;
            cap_reg   <= size_to_cap(CFG_W'(SIZE_RESET));
        end
        else
        begin
            if (advance)
            begin
                obj_reg   <= obj_next;
                str_reg   <= str_next;
                esc_reg   <= esc_next;
                depth_reg <= depth_next;
                cnt_reg   <= cnt_next;
                ovf_reg   <= ovf_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= size_to_cap(cfg.frame_buffer_bytes);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && emit)
        begin
            out_reg <= res_next;
        end
    end

    assign frame.valid          = out_valid_reg;
    assign frame.frame_byte     = out_reg.frame_byte;
    assign frame.is_first       = out_reg.is_first;
    assign frame.is_last        = out_reg.is_last;
    assign frame.aborted        = out_reg.aborted;
    assign frame.frame_length   = out_reg.frame_length;
    assign frame.overflow_total = out_reg.overflow_total;

    // between objects the string, depth and count state is all clear
    `BBOF_ASSERT_SAME(a_idle_clear, !obj_reg,
        !str_reg && !esc_reg && depth_reg == '0 && cnt_reg == '0)
    // an escape can only be pending inside a string
    `BBOF_ASSERT_SAME(a_esc_in_str, esc_reg, str_reg)
    // every abort bumps the overflow counter by exactly one
    `BBOF_ASSERT_NEXT(a_abort_count, advance && abort,
        ovf_reg == OVF_W'($past(ovf_reg) + OVF_W'(1)))
    // an aborted result carries no byte and no marks
    `BBOF_ASSERT_SAME(a_abort_fields, out_valid_reg && out_reg.aborted,
        !out_reg.is_first && !out_reg.is_last && out_reg.frame_length == '0)

endmodule

### sim/testbench.sv
module testbench;
    import bbof_pkg::*;

    // largest effective buffer size after clamping
    localparam int SIZE_TOP  = (BUFFER_LIMIT < 4096) ? BUFFER_LIMIT : 4096;
    localparam int SIZE_CEIL = (SIZE_TOP < 2) ? 2 : SIZE_TOP;

    localparam int MAX_WAIT     = 10;    // per-item idle draw on either side
    localparam int LONG_HOLD    = 400;   // receiver hold-off that backs the block up
    localparam int DRAIN_CYCLES = 8;     // drain slack after the last result is seen
    localparam int STALL_LIMIT  = 4000;  // watchdog, cycles without any transfer
    localparam int PRINT_CAP    = 40;

    localparam logic [BYTE_W-1:0] PLAIN_SUBST = 8'h3A;

    logic clk = 1'b0;
    logic rst_n;

    bbof_rx_if    rx_ch();
    bbof_frame_if frame_ch();
    bbof_cfg_if   cfg_ch();

    brace_balanced_object_framer_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // framer state as the testbench sees it
    logic [CFG_W-1:0]   size_reg;
    logic               in_object;
    logic               in_string;
    logic               escape_next;
    logic [DEPTH_W-1:0] depth;
    logic [LEN_W-1:0]   stored;
    logic [OVF_W-1:0]   overflows;

    frame_t            frame_expect[$];  // predicted frame transfers, oldest first
    logic [BYTE_W-1:0] byte_backlog[$];  // bytes waiting to go out on rx
    logic [BYTE_W-1:0] obj_bytes[$];     // scratch for one generated object
    frame_t            frame_want;

    int mismatches    = 0;
    int hold_requests = 0;
    int quiet_cycles  = 0;
    bit no_idle       = 1'b0;            // both sides run flat out

    // driver and monitor locals
    int gap_left;
    bit rx_burst;
    int stall_left;
    int hold_left;
    int hold_served;
    bit frame_burst;
    int wait_draw;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [OVF_W-1:0] got,
                               input logic [OVF_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    task automatic drop_object();
        in_object   = 1'b0;
        in_string   = 1'b0;
        escape_next = 1'b0;
        depth       = '0;
        stored      = '0;
    endtask

    // advance the framer state by one accepted byte, queue the transfer it causes
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        frame_t           res;
        int               eff;
        logic [LEN_W-1:0] cap;
        bit               opening;
        eff = int'(size_reg);
        if (eff < 2)
        begin
            eff = 2;
        end
        if (eff > SIZE_CEIL)
        begin
            eff = SIZE_CEIL;
        end
        cap     = LEN_W'(eff - 1);
        res     = '0;
        opening = 1'b0;

        // carriage returns vanish everywhere
        if (b == CH_CR)
        begin
            return;
        end

        if (!in_object)
        begin
            // between objects only an opening brace matters
            if (b != CH_OPEN)
            begin
                return;
            end
            drop_object();
            in_object = 1'b1;
            depth     = DEPTH_W'(1);
            opening   = 1'b1;
        end
        else if (in_string)
        begin
            if (escape_next)
            begin
                escape_next = 1'b0;
            end
            else if (b == CH_BSLASH)
            begin
                escape_next = 1'b1;
            end
            else if (b == CH_QUOTE)
            begin
                in_string = 1'b0;
            end
        end
        else if (b == CH_QUOTE)
        begin
            in_string = 1'b1;
        end
        else if (b == CH_OPEN)
        begin
            depth = depth + DEPTH_W'(1);
        end
        else if (b == CH_CLOSE)
        begin
            depth = depth - DEPTH_W'(1);
        end

        if (stored >= cap)
        begin
            // frame too long: discard it, fields stay zero
            overflows = overflows + OVF_W'(1);
            drop_object();
            res.aborted = 1'b1;
        end
        else
        begin
            stored             = stored + LEN_W'(1);
            res.frame_byte     = b;
            res.is_first       = opening;
            res.frame_length   = stored;
            if (!in_string && depth == '0)
            begin
                res.is_last = 1'b1;
                drop_object();
            end
        end
        res.overflow_total = overflows;
        frame_expect.push_back(res);
    endtask

    // random byte with the framing characters mapped away
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom_range(0, 255));
        if (v == CH_QUOTE || v == CH_BSLASH || v == CH_OPEN || v == CH_CLOSE)
        begin
            v = PLAIN_SUBST;
        end
        return v;
    endfunction

    // well-formed object with nesting, strings, escapes and stray carriage returns
    task automatic build_object(input int max_body);
        int open_depth;
        int body;
        int n;
        int r;
        obj_bytes.delete();
        obj_bytes.push_back(CH_OPEN);
        open_depth = 1;
        body       = $urandom_range(0, max_body);
        for (n = 0; n < body; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                obj_bytes.push_back(CH_OPEN);
                open_depth++;
            end
            else if (r < 22 && open_depth > 1)
            begin
                obj_bytes.push_back(CH_CLOSE);
                open_depth--;
            end
            else if (r < 35)
            begin
                // quoted string, braces inside must not count
                obj_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 9))
                        0: obj_bytes.push_back(CH_OPEN);
                        1: obj_bytes.push_back(CH_CLOSE);
                        2:
                        begin
                            obj_bytes.push_back(CH_BSLASH);
                            obj_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
                        end
                        3: obj_bytes.push_back(CH_CR);
                        default: obj_bytes.push_back(plain_byte());
                    endcase
                end
                obj_bytes.push_back(CH_QUOTE);
            end
            else if (r < 40)
            begin
                obj_bytes.push_back(CH_CR);
            end
            else
            begin
                obj_bytes.push_back(plain_byte());
            end
        end
        while (open_depth > 0)
        begin
            obj_bytes.push_back(CH_CLOSE);
            open_depth--;
        end
    endtask

    // mostly whole objects, some line noise and some damaged objects
    task automatic queue_random_traffic(input int target, input int max_body);
        int useful;
        int kind;
        int cut;
        useful = 0;
        while (useful < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    byte_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
                end
            end
            else
            begin
                build_object(max_body);
                if (kind == 1)
                begin
                    // damaged: cut short, or one byte replaced by anything
                    cut = $urandom_range(0, obj_bytes.size() - 1);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        while (obj_bytes.size() > cut + 1)
                        begin
                            void'(obj_bytes.pop_back());
                        end
                    end
                    else
                    begin
                        obj_bytes[cut] = BYTE_W'($urandom_range(0, 255));
                    end
                end
                useful += obj_bytes.size();
                foreach (obj_bytes[j])
                begin
                    byte_backlog.push_back(obj_bytes[j]);
                end
            end
        end
    endtask

    // one register write, then back to the falling edge for stimulus setup
    task automatic write_buffer_size(input logic [CFG_W-1:0] value);
        cfg_ch.valid              <= 1'b1;
        cfg_ch.frame_buffer_bytes <= value;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        size_reg = value;
        @(negedge clk);
    endtask

    // wait until every byte is taken and every result seen, plus pipeline slack
    task automatic drain_stream();
        while (byte_backlog.size() != 0 || rx_ch.valid || frame_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // rx driver: one transfer per queued byte, idle gap drawn per byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            gap_left      <= 0;
            rx_burst      <= 1'b0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                predict_byte(rx_ch.rx_byte);
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    rx_ch.valid <= 1'b0;
                    gap_left    <= gap_left - 1;
                end
                else if (byte_backlog.size() != 0)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= byte_backlog.pop_front();
                    // now and then switch between gappy and back-to-back runs
                    if ($urandom_range(0, 49) == 0)
                    begin
                        rx_burst <= !rx_burst;
                    end
                    gap_left <= (no_idle || rx_burst) ? 0 : $urandom_range(0, MAX_WAIT);
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // frame monitor: checks every transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
            stall_left     <= 0;
            hold_left      <= 0;
            hold_served    <= 0;
            frame_burst    <= 1'b0;
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (frame_expect.size() == 0)
                begin
                    report_mismatch("frame transfer with nothing predicted");
                end
                else
                begin
                    frame_want = frame_expect.pop_front();
                    check_field("frame_byte", OVF_W'(frame_ch.frame_byte),
                                OVF_W'(frame_want.frame_byte));
                    check_field("is_first", OVF_W'(frame_ch.is_first),
                                OVF_W'(frame_want.is_first));
                    check_field("is_last", OVF_W'(frame_ch.is_last),
                                OVF_W'(frame_want.is_last));
                    check_field("aborted", OVF_W'(frame_ch.aborted),
                                OVF_W'(frame_want.aborted));
                    check_field("frame_length", OVF_W'(frame_ch.frame_length),
                                OVF_W'(frame_want.frame_length));
                    check_field("overflow_total", frame_ch.overflow_total,
                                frame_want.overflow_total);
                end
            end

            if (hold_served != hold_requests)
            begin
                // long hold-off: the sender keeps offering, so the block backs up
                hold_served    <= hold_requests;
                hold_left      <= LONG_HOLD;
                frame_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left      <= hold_left - 1;
                frame_ch.ready <= (hold_left == 1);
            end
            else if (frame_ch.valid && frame_ch.ready)
            begin
                // stall before the next transfer, drawn per item
                if ($urandom_range(0, 49) == 0)
                begin
                    frame_burst <= !frame_burst;
                end
                wait_draw = (no_idle || frame_burst) ? 0 : $urandom_range(0, MAX_WAIT);
                stall_left     <= wait_draw;
                frame_ch.ready <= (wait_draw == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left     <= stall_left - 1;
                frame_ch.ready <= (stall_left == 1);
            end
            else
            begin
                frame_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, frame_expect.size());
                $display("brace_balanced_object_framer_top verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        // every block input known from time zero
        rst_n                     = 1'b0;
        rx_ch.valid               = 1'b0;
        rx_ch.rx_byte             = '0;
        frame_ch.ready            = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.frame_buffer_bytes = '0;
        size_reg                  = CFG_W'(SIZE_RESET);
        overflows                 = '0;
        drop_object();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, at the reset buffer size:
        // junk between objects, braces and escaped quote inside a string,
        // smallest object, escape carried across a carriage return
        byte_backlog = '{CH_CR, 8'h00, 8'hFF, CH_CLOSE, CH_QUOTE,
                         CH_OPEN, CH_CR, CH_QUOTE, CH_OPEN, CH_BSLASH, CH_QUOTE,
                         CH_CLOSE, CH_QUOTE, CH_CLOSE,
                         CH_OPEN, CH_CLOSE,
                         CH_OPEN, CH_QUOTE, CH_BSLASH, CH_CR, CH_QUOTE, CH_QUOTE,
                         CH_CLOSE};
        drain_stream();

        // below the minimum, clamps to two: only the opening brace fits
        write_buffer_size(CFG_W'(0));
        queue_random_traffic(150, 4);
        drain_stream();

        write_buffer_size(CFG_W'(3));
        queue_random_traffic(150, 4);
        drain_stream();

        write_buffer_size(CFG_W'(8));
        queue_random_traffic(200, 8);
        drain_stream();

        // mid-size frames with a long receiver hold-off while rx keeps offering
        write_buffer_size(CFG_W'(40));
        queue_random_traffic(300, 30);
        hold_requests++;
        drain_stream();

        write_buffer_size(CFG_W'(4096));
        queue_random_traffic(150, 60);
        drain_stream();

        // top of the register, clamps to the ceiling
        write_buffer_size(CFG_W'(8191));
        queue_random_traffic(100, 20);
        drain_stream();

        write_buffer_size(CFG_W'(4097));
        queue_random_traffic(100, 20);
        drain_stream();

        write_buffer_size(CFG_W'($urandom_range(2, 200)));
        queue_random_traffic(250, 40);
        drain_stream();

        // smallest size with both sides running flat out
        write_buffer_size(CFG_W'(2));
        no_idle = 1'b1;
        queue_random_traffic(100, 3);
        drain_stream();
        no_idle = 1'b0;

        write_buffer_size(CFG_W'(SIZE_RESET));
        queue_random_traffic(100, 20);
        drain_stream();

        if (mismatches == 0)
        begin
            $display("brace_balanced_object_framer_top verification clean");
        end
        else
        begin
            $display("brace_balanced_object_framer_top verification failed");
        end
        $finish;
    end

endmodule
